[rtl/page_state_table_free_run_scan_defines.svh]
// Assertion macros shared by the page state table RTL.
`ifndef PAGE_STATE_TABLE_FREE_RUN_SCAN_DEFINES_SVH
`define PAGE_STATE_TABLE_FREE_RUN_SCAN_DEFINES_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define PST_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked at every rising edge outside reset.
`define PST_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/pst_pkg.sv]
// Types and constants of the page state table.
package pst_pkg;

    localparam int MAX_PAGES_DEF = 4096;
    localparam int ADDR_W        = 64;
    localparam int PAGE_SHIFT    = 12;
    localparam int PAGE_COUNT_W  = 13;
    localparam int STATE_W       = 3;
    localparam int ENTRY_W       = 5;
    localparam int RUN_BASE_W    = 24;
    localparam int RUN_SIZE_W    = 25;

    // Entry layout: page state, allocatable mark, referenced mark.
    localparam int ENTRY_ALLOC_BIT = 3;
    localparam int ENTRY_REF_BIT   = 4;

    localparam logic [STATE_W-1:0] PAGE_FREE     = 3'd0;
    localparam logic [STATE_W-1:0] PAGE_RESERVED = 3'd1;

    localparam logic [1:0] OP_MARK_RANGE    = 2'd0;
    localparam logic [1:0] OP_SET_RANGE     = 2'd1;
    localparam logic [1:0] OP_NEXT_FREE_RUN = 2'd2;
    // The last code does nothing and returns an all-zero result.
    localparam logic [1:0] OP_RESERVED      = 2'd3;

    localparam int                REG_ADDR_W          = 1;
    localparam logic [REG_ADDR_W-1:0] REG_PAGE_COUNT = 1'b0;

    typedef struct packed {
        logic [1:0]              operation;
        logic [ADDR_W-1:0]       base_address;
        logic [ADDR_W-1:0]       region_bytes;
        logic [PAGE_COUNT_W-1:0] region_pages;
        logic [STATE_W-1:0]      page_state;
        logic                    allocatable;
    } t_in_item;

    typedef struct packed {
        logic                  applied;
        logic                  found;
        logic [RUN_BASE_W-1:0] run_base;
        logic [RUN_SIZE_W-1:0] run_size;
    } t_out_item;

endpackage

[rtl/pst_chan_if.sv]
// Valid/ready channel carrying one item of a given payload type.
interface pst_chan_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

[rtl/page_state_table_free_run_scan.sv]
// Page state table with range marking, range setting and a free-run scanner.
//
// Items arrive on i_req (valid/ready) and each produces exactly one result item
// on o_rsp (valid/ready). page_count is written over the APB port at address 0.
// After reset the table is swept to "reserved, not allocatable, unreferenced",
// one entry per cycle, so the block takes no item until all MAX_PAGES entries
// are swept; configuration writes are taken meanwhile.
// One table memory port pair (one write, one registered read) sets the rate:
// every entry visited costs one cycle.
//   mark_range:    ST_PREP, ST_MARK_IDX, then ST_MARK for each page written, then ST_DONE to deliver.
//   set_range:     ST_PREP, then ST_SET for each page written, then ST_DONE to deliver.
//   next_free_run: ST_PREP, then ST_SCAN for each entry scanned, then ST_DONE to deliver.
// One item is in work at a time. A finished result waits in the output register
// while the next item is taken; if the result of that next item is ready before
// the receiver takes the first, it waits in the block until the output register
// frees up.
`include "page_state_table_free_run_scan_defines.svh"

module page_state_table_free_run_scan #(
    parameter int MAX_PAGES = pst_pkg::MAX_PAGES_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    pst_chan_if.sink                        i_req,
    pst_chan_if.source                      o_rsp,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [pst_pkg::REG_ADDR_W-1:0]  paddr,
    input  logic [31:0]                     pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready
);
    import pst_pkg::*;

    localparam int IW = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;

    localparam logic [2:0] ST_CLEAR    = 3'd0;
    localparam logic [2:0] ST_IDLE     = 3'd1;
    localparam logic [2:0] ST_PREP     = 3'd2;
    localparam logic [2:0] ST_MARK_IDX = 3'd3;
    localparam logic [2:0] ST_MARK     = 3'd4;
    localparam logic [2:0] ST_SET      = 3'd5;
    localparam logic [2:0] ST_SCAN     = 3'd6;
    localparam logic [2:0] ST_DONE     = 3'd7;

    logic [2:0]              r_state, n_state;
    logic [IW-1:0]           r_clr_idx, n_clr_idx;
    logic [PAGE_COUNT_W-1:0] r_page_count;
    logic [PAGE_COUNT_W-1:0] r_cursor, n_cursor;
    logic [PAGE_COUNT_W-1:0] r_idx, n_idx;
    logic [PAGE_COUNT_W-1:0] r_end, n_end;
    logic [PAGE_COUNT_W-1:0] r_run_start, n_run_start;
    logic                    r_in_run, n_in_run;
    logic [ADDR_W:0]         r_sum, n_sum;
    t_in_item                r_item;
    t_out_item               r_res, n_res;
    t_out_item               r_out;
    logic                    r_out_valid;
    logic                    out_load;

    logic [ENTRY_W-1:0]      r_mem [MAX_PAGES];
    logic [ENTRY_W-1:0]      r_rdata;
    logic                    mem_we;
    logic [IW-1:0]           mem_addr;
    logic [ENTRY_W-1:0]      mem_wdata;

    logic [PAGE_COUNT_W-1:0] act_cnt;
    logic                    in_accept;
    logic                    cfg_write;
    logic [PAGE_COUNT_W-1:0] first_page;
    logic                    start_ok;
    logic [PAGE_COUNT_W:0]   set_end_full;
    logic [PAGE_COUNT_W-1:0] set_end;
    logic [PAGE_COUNT_W:0]   mark_end_full;
    logic                    mark_end_big;
    logic [PAGE_COUNT_W-1:0] mark_end;
    logic                    entry_free;
    logic [PAGE_COUNT_W-1:0] idx_inc;
    logic                    idx_last;

    // Configuration port.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign prdata    = (paddr == REG_PAGE_COUNT)
                       ? {{(32 - PAGE_COUNT_W){1'b0}}, r_page_count} : 32'd0;

    assign act_cnt = (32'(r_page_count) > 32'(MAX_PAGES))
                     ? PAGE_COUNT_W'(MAX_PAGES) : r_page_count;

    assign i_req.ready = (r_state == ST_IDLE);
    assign in_accept   = i_req.valid && i_req.ready;
    assign o_rsp.valid   = r_out_valid;
    assign o_rsp.payload = r_out;

    // Start page of a range; it lies in the table only if the upper bits are clear.
    assign first_page = r_item.base_address[PAGE_SHIFT +: PAGE_COUNT_W];
    assign start_ok   = (r_item.base_address[ADDR_W-1:PAGE_SHIFT+PAGE_COUNT_W] == '0)
                        && (first_page < act_cnt);

    assign set_end_full = {1'b0, first_page} + {1'b0, r_item.region_pages};
    assign set_end      = (set_end_full > {1'b0, act_cnt})
                          ? act_cnt : set_end_full[PAGE_COUNT_W-1:0];

    // End page is the ceiling of the end address over the page size.
    assign mark_end_big  = (r_sum[ADDR_W-1:PAGE_SHIFT+PAGE_COUNT_W] != '0);
    assign mark_end_full = {1'b0, r_sum[PAGE_SHIFT +: PAGE_COUNT_W]}
                           + {{PAGE_COUNT_W{1'b0}}, (r_sum[PAGE_SHIFT-1:0] != '0)};
    assign mark_end      = (mark_end_big || (mark_end_full > {1'b0, act_cnt}))
                           ? act_cnt : mark_end_full[PAGE_COUNT_W-1:0];

    assign entry_free = (r_rdata[STATE_W-1:0] == PAGE_FREE) && r_rdata[ENTRY_ALLOC_BIT]
                        && !r_rdata[ENTRY_REF_BIT];
    assign idx_inc    = r_idx + 1'b1;
    assign idx_last   = (idx_inc == act_cnt);

    assign out_load = (r_state == ST_DONE) && (!r_out_valid || o_rsp.ready);

    always_comb begin
        n_state     = r_state;
        n_clr_idx   = r_clr_idx;
        n_cursor    = r_cursor;
        n_idx       = r_idx;
        n_end       = r_end;
        n_run_start = r_run_start;
        n_in_run    = r_in_run;
        n_sum       = r_sum;
        n_res       = r_res;
        mem_we      = 1'b0;
        mem_addr    = IW'(r_idx);
        mem_wdata   = '0;
        case (r_state)
            ST_CLEAR: begin
                mem_we    = 1'b1;
                mem_addr  = r_clr_idx;
                mem_wdata = {1'b0, 1'b0, PAGE_RESERVED};
                n_clr_idx = r_clr_idx + 1'b1;
                if (r_clr_idx == IW'(MAX_PAGES - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (in_accept) begin
                    n_state = ST_PREP;
                end
            end
            ST_PREP: begin
                n_res = '0;
                case (r_item.operation)
                    OP_MARK_RANGE: begin
                        n_sum   = {1'b0, r_item.base_address} + {1'b0, r_item.region_bytes};
                        n_state = ST_MARK_IDX;
                    end
                    OP_SET_RANGE: begin
                        n_idx = first_page;
                        n_end = set_end;
                        if (start_ok && (set_end > first_page)) begin
                            n_res.applied = 1'b1;
                            n_state       = ST_SET;
                        end else begin
                            n_state = ST_DONE;
                        end
                    end
                    OP_NEXT_FREE_RUN: begin
                        n_idx    = r_cursor;
                        n_in_run = 1'b0;
                        if (r_cursor >= act_cnt) begin
                            n_cursor = '0;
                            n_state  = ST_DONE;
                        end else begin
                            n_state = ST_SCAN;
                        end
                    end
                    default: begin
                        n_state = ST_DONE;
                    end
                endcase
            end
            ST_MARK_IDX: begin
                n_idx = first_page;
                n_end = mark_end;
                // Zero length and a range that runs past the address space are ignored.
                if ((r_item.region_bytes != '0) && !r_sum[ADDR_W] && start_ok
                    && (mark_end > first_page)) begin
                    n_res.applied = 1'b1;
                    n_state       = ST_MARK;
                end else begin
                    n_state = ST_DONE;
                end
            end
            ST_MARK: begin
                mem_we    = 1'b1;
                mem_wdata = {1'b0, r_item.allocatable, r_item.page_state};
                n_idx     = idx_inc;
                if (idx_inc == r_end) begin
                    n_state = ST_DONE;
                end
            end
            ST_SET: begin
                // The read of this entry was issued in the previous cycle; keep its allocatable mark.
                mem_we    = 1'b1;
                mem_wdata = {1'b1, r_rdata[ENTRY_ALLOC_BIT], r_item.page_state};
                n_idx     = idx_inc;
                if (idx_inc == r_end) begin
                    n_state = ST_DONE;
                end
            end
            ST_SCAN: begin
                if (!r_in_run) begin
                    if (entry_free) begin
                        n_run_start = r_idx;
                        n_in_run    = 1'b1;
                        if (idx_last) begin
                            n_res.found    = 1'b1;
                            n_res.run_base = {r_idx[RUN_BASE_W-PAGE_SHIFT-1:0],
                                              {PAGE_SHIFT{1'b0}}};
                            n_res.run_size = {PAGE_COUNT_W'(1), {PAGE_SHIFT{1'b0}}};
                            n_cursor       = idx_inc;
                            n_state        = ST_DONE;
                        end else begin
                            n_idx = idx_inc;
                        end
                    end else if (idx_last) begin
                        n_cursor = '0;
                        n_state  = ST_DONE;
                    end else begin
                        n_idx = idx_inc;
                    end
                end else if (entry_free && !idx_last) begin
                    n_idx = idx_inc;
                end else begin
                    n_res.found    = 1'b1;
                    n_res.run_base = {r_run_start[RUN_BASE_W-PAGE_SHIFT-1:0],
                                      {PAGE_SHIFT{1'b0}}};
                    if (entry_free) begin
                        n_res.run_size = {idx_inc - r_run_start, {PAGE_SHIFT{1'b0}}};
                        n_cursor       = idx_inc;
                    end else begin
                        n_res.run_size = {r_idx - r_run_start, {PAGE_SHIFT{1'b0}}};
                        n_cursor       = r_idx;
                    end
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_load) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_CLEAR;
            r_clr_idx    <= '0;
            r_page_count <= '0;
            r_cursor     <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_clr_idx <= n_clr_idx;
            r_cursor  <= n_cursor;
            if (cfg_write && (paddr == REG_PAGE_COUNT)) begin
                r_page_count <= pwdata[PAGE_COUNT_W-1:0];
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx       <= n_idx;
        r_end       <= n_end;
        r_run_start <= n_run_start;
        r_in_run    <= n_in_run;
        r_sum       <= n_sum;
        r_res       <= n_res;
        if (in_accept) begin
            r_item <= i_req.payload;
        end
        if (out_load) begin
            r_out <= r_res;
        end
    end

    // Table memory; the read follows the next index so data for r_idx is ready.
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_addr] <= mem_wdata;
        end
        r_rdata <= r_mem[IW'(n_idx)];
    end

    `PST_ASSERT_IMP(a_no_item_while_clearing, i_clk, i_rst_n,
        r_state == ST_CLEAR, !i_req.ready, "item taken during the clearing pass")
    `PST_ASSERT_IMP(a_write_in_range, i_clk, i_rst_n,
        mem_we && (r_state != ST_CLEAR), r_idx < r_end, "table write past range end")
    `PST_ASSERT_IMP(a_applied_found_excl, i_clk, i_rst_n,
        r_out_valid, !(r_out.applied && r_out.found), "applied and found both set")
    `PST_ASSERT_NXT(a_accept_leaves_idle, i_clk, i_rst_n,
        in_accept, r_state == ST_PREP, "accepted item did not start work")

endmodule

[test/tb_top.sv]
// Self-checking testbench for the page state table with range marking and free-run scanning.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import pst_pkg::*;

    localparam int WATCHDOG_LIMIT  = 20000;
    localparam int RSP_HOLD_CYCLES = 300;
    localparam int PHASE_PAUSE     = 8;
    localparam int DRAIN_CYCLES    = MAX_PAGES_DEF + 16;

    typedef struct packed {
        bit               referenced;
        bit               allocatable;
        bit [STATE_W-1:0] state;
    } t_page_entry;

    // Tracks the page table, the scan cursor and the results still owed by the block.
    class page_table_scoreboard;
        t_page_entry             page_tbl [MAX_PAGES_DEF];
        bit [PAGE_COUNT_W-1:0]   scan_pos;
        bit [PAGE_COUNT_W-1:0]   page_limit;
        t_out_item               owed_results [$];
        int                      mismatches;

        function new();
            foreach (page_tbl[i]) page_tbl[i] = '{referenced: 1'b0, allocatable: 1'b0,
                                                   state: PAGE_RESERVED};
            scan_pos   = '0;
            page_limit = '0;
            mismatches = 0;
        endfunction

        function void set_page_count(bit [PAGE_COUNT_W-1:0] value);
            page_limit = value;
        endfunction

        function int pending();
            return owed_results.size();
        endfunction

        function bit page_is_free(longint unsigned idx);
            return page_tbl[idx].state == PAGE_FREE && page_tbl[idx].allocatable &&
                   !page_tbl[idx].referenced;
        endfunction

        function t_out_item apply_item(t_in_item it);
            t_out_item             res;
            longint unsigned       cnt;
            logic [ADDR_W-1:0]     stop_addr;
            longint unsigned       first_pg;
            longint unsigned       end_pg;
            longint unsigned       idx;
            res = '0;
            cnt = (page_limit > MAX_PAGES_DEF) ? MAX_PAGES_DEF : page_limit;
            case (it.operation)
                OP_MARK_RANGE: begin
                    if (it.region_bytes != 0 && it.base_address <= ~64'd0 - it.region_bytes) begin
                        stop_addr = it.base_address + it.region_bytes;
                        first_pg  = it.base_address >> PAGE_SHIFT;
                        // The end page rounds up, so a partial last page is covered.
                        end_pg    = (stop_addr >> PAGE_SHIFT) +
                                    64'(stop_addr[PAGE_SHIFT-1:0] != 0);
                        if (first_pg < cnt) begin
                            if (end_pg > cnt) end_pg = cnt;
                            for (idx = first_pg; idx < end_pg; idx++) begin
                                page_tbl[idx] = '{referenced: 1'b0,
                                                  allocatable: it.allocatable,
                                                  state: it.page_state};
                            end
                            res.applied = end_pg > first_pg;
                        end
                    end
                end
                OP_SET_RANGE: begin
                    first_pg = it.base_address >> PAGE_SHIFT;
                    if (first_pg < cnt) begin
                        end_pg = first_pg + it.region_pages;
                        if (end_pg > cnt) end_pg = cnt;
                        for (idx = first_pg; idx < end_pg; idx++) begin
                            page_tbl[idx].state      = it.page_state;
                            page_tbl[idx].referenced = 1'b1;
                        end
                        res.applied = end_pg > first_pg;
                    end
                end
                OP_NEXT_FREE_RUN: begin
                    idx = scan_pos;
                    while (idx < cnt && !page_is_free(idx)) idx++;
                    if (idx >= cnt) begin
                        scan_pos = '0;
                    end else begin
                        first_pg = idx;
                        while (idx < cnt && page_is_free(idx)) idx++;
                        scan_pos     = idx[PAGE_COUNT_W-1:0];
                        res.found    = 1'b1;
                        res.run_base = RUN_BASE_W'(first_pg << PAGE_SHIFT);
                        res.run_size = RUN_SIZE_W'((idx - first_pg) << PAGE_SHIFT);
                    end
                end
                default: ;
            endcase
            return res;
        endfunction

        function void note_item(t_in_item it);
            owed_results.push_back(apply_item(it));
        endfunction

        function void check_result(t_out_item got);
            t_out_item want;
            if (owed_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: unexpected result applied=%0b found=%0b base=%h size=%h",
                             $realtime, got.applied, got.found, got.run_base, got.run_size);
                return;
            end
            want = owed_results.pop_front();
            if (got.applied !== want.applied || got.found !== want.found ||
                got.run_base !== want.run_base || got.run_size !== want.run_size) begin
                mismatches++;
                if (mismatches <= 10)
                    $display({"%0t: result differs: applied %0b/%0b found %0b/%0b ",
                              "base %h/%h size %h/%h (expected/actual)"}, $realtime,
                             want.applied, got.applied, want.found, got.found,
                             want.run_base, got.run_base, want.run_size, got.run_size);
            end
        endfunction
    endclass

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [REG_ADDR_W-1:0] paddr;
    logic [31:0]           pwdata;
    logic [31:0]           prdata;
    logic                  pready;

    pst_chan_if #(.T(t_in_item))  req_ch ();
    pst_chan_if #(.T(t_out_item)) rsp_ch ();

    page_table_scoreboard sb = new();

    bit send_steady;
    bit hold_off_request;
    int idle_cycles;

    page_state_table_free_run_scan DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // Mostly short idle spans, now and then a long one.
    function automatic int idle_span();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return $urandom_range(1, 2);
        if (r < 90) return $urandom_range(3, 8);
        return $urandom_range(15, 60);
    endfunction

    function automatic t_in_item make_item(logic [1:0] op, logic [ADDR_W-1:0] base,
                                           logic [ADDR_W-1:0] bytes,
                                           logic [PAGE_COUNT_W-1:0] pages,
                                           logic [STATE_W-1:0] st, logic alloc);
        t_in_item it;
        it.operation    = op;
        it.base_address = base;
        it.region_bytes = bytes;
        it.region_pages = pages;
        it.page_state   = st;
        it.allocatable  = alloc;
        return it;
    endfunction

    // Mostly in-table ranges that build and break free runs, with some wild values mixed in.
    function automatic t_in_item random_item(int cnt);
        t_in_item it;
        int       r;
        r = $urandom_range(0, 99);
        if (r < 35) it.operation = OP_MARK_RANGE;
        else if (r < 55) it.operation = OP_SET_RANGE;
        else if (r < 97) it.operation = OP_NEXT_FREE_RUN;
        else it.operation = OP_RESERVED;
        if ($urandom_range(0, 4) == 0)
            it.base_address = {$urandom, $urandom};
        else
            it.base_address = (64'($urandom_range(0, cnt + 1)) << PAGE_SHIFT) |
                              ($urandom_range(0, 1) ? 64'($urandom_range(0, 4095)) : 64'd0);
        case ($urandom_range(0, 9))
            0: it.region_bytes = '0;
            1: it.region_bytes = {$urandom, $urandom};
            2: it.region_bytes = ~64'd0 - it.base_address + 64'($urandom_range(0, 2));
            default: it.region_bytes = 64'($urandom_range(1, 6 * 4096));
        endcase
        r = $urandom_range(0, 99);
        if (r < 75) it.region_pages = PAGE_COUNT_W'($urandom_range(0, 8));
        else if (r < 90) it.region_pages = PAGE_COUNT_W'($urandom_range(0, MAX_PAGES_DEF));
        else it.region_pages = PAGE_COUNT_W'($urandom_range(0, 8191));
        it.page_state  = $urandom_range(0, 1) ? PAGE_FREE : STATE_W'($urandom_range(0, 7));
        it.allocatable = $urandom_range(0, 3) != 0;
        return it;
    endfunction

    task automatic drive_item(input t_in_item it);
        int gap;
        gap = (!send_steady && $urandom_range(0, 2) == 0) ? idle_span() : 0;
        @(negedge i_clk);
        if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        req_ch.valid   <= 1'b1;
        req_ch.payload <= it;
        @(posedge i_clk);
        while (!req_ch.ready) @(posedge i_clk);
        sb.note_item(it);
    endtask

    task automatic drive_random(input int n, input int cnt);
        repeat (n) drive_item(random_item(cnt));
    endtask

    // Lower valid and wait until every owed result has come back.
    task automatic settle(input int pause);
        @(negedge i_clk);
        req_ch.valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (pause) @(posedge i_clk);
    endtask

    task automatic write_page_count(input logic [PAGE_COUNT_W-1:0] value);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= REG_PAGE_COUNT;
        pwdata  <= 32'(value);
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        sb.set_page_count(value);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Receiver: each stretch runs either at full speed or with random stalls, chosen at random.
    initial begin
        int  stall_left;
        int  stretch_left;
        bit  steady;
        stall_left   = 0;
        stretch_left = 0;
        steady       = 1'b0;
        rsp_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_off_request) begin
                rsp_ch.ready <= 1'b0;
                repeat (RSP_HOLD_CYCLES) @(negedge i_clk);
                hold_off_request = 1'b0;
                rsp_ch.ready <= 1'b1;
            end else if (stall_left > 0) begin
                rsp_ch.ready <= 1'b0;
                stall_left--;
            end else begin
                if (stretch_left == 0) begin
                    steady       = $urandom_range(0, 3) == 0;
                    stretch_left = $urandom_range(20, 150);
                end
                stretch_left--;
                if (!steady && $urandom_range(0, 2) == 0) begin
                    stall_left = idle_span() - 1;
                    rsp_ch.ready <= 1'b0;
                end else begin
                    rsp_ch.ready <= 1'b1;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && rsp_ch.valid && rsp_ch.ready) sb.check_result(rsp_ch.payload);
    end

    initial begin
        idle_cycles = 0;
        forever begin
            @(posedge i_clk);
            if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) break;
        end
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin
        req_ch.valid     = 1'b0;
        req_ch.payload   = '0;
        psel             = 1'b0;
        penable          = 1'b0;
        pwrite           = 1'b0;
        paddr            = '0;
        pwdata           = '0;
        i_rst_n          = 1'b0;
        send_steady      = 1'b0;
        hold_off_request = 1'b0;
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Empty table right after reset: nothing applies and nothing is found.
        drive_item(make_item(OP_NEXT_FREE_RUN, '0, '0, '0, PAGE_FREE, 1'b0));
        drive_item(make_item(OP_MARK_RANGE, '0, 64'h1000, '0, PAGE_FREE, 1'b1));
        drive_item(make_item(OP_SET_RANGE, '0, '0, 13'd4, PAGE_FREE, 1'b0));
        settle(PHASE_PAUSE);

        // Largest register value, which behaves as a full table.
        write_page_count(13'h1FFF);
        drive_item(make_item(OP_NEXT_FREE_RUN, '0, '0, '0, PAGE_FREE, 1'b0));
        drive_item(make_item(OP_MARK_RANGE, 64'h1000, '0, '0, PAGE_FREE, 1'b1));
        drive_item(make_item(OP_MARK_RANGE, 64'hFFFF_FFFF_FFFF_F000, 64'h2000, '0,
                             PAGE_FREE, 1'b1));
        drive_item(make_item(OP_MARK_RANGE, ~64'd0, 64'd1, '0, PAGE_FREE, 1'b1));
        drive_item(make_item(OP_MARK_RANGE, '0, ~64'd0, '0, PAGE_FREE, 1'b1));
        drive_item(make_item(OP_NEXT_FREE_RUN, '0, '0, '0, PAGE_FREE, 1'b0));
        drive_item(make_item(OP_NEXT_FREE_RUN, '0, '0, '0, PAGE_FREE, 1'b0));
        drive_item(make_item(OP_SET_RANGE, 64'h1000, '0, 13'd3, 3'd6, 1'b0));
        drive_item(make_item(OP_MARK_RANGE, 64'h5001, 64'h1FFF, '0, 3'd5, 1'b1));
        drive_item(make_item(OP_MARK_RANGE, 64'h9FFF, 64'd2, '0, 3'd7, 1'b0));
        drive_item(make_item(OP_SET_RANGE, 64'(4095) << PAGE_SHIFT, '0, 13'h1FFF,
                             PAGE_FREE, 1'b1));
        drive_item(make_item(OP_SET_RANGE, 64'(4096) << PAGE_SHIFT, '0, 13'd1, 3'd2, 1'b0));
        drive_item(make_item(OP_MARK_RANGE, 64'(4096) << PAGE_SHIFT, 64'd1, '0,
                             PAGE_FREE, 1'b1));
        drive_item(make_item(OP_SET_RANGE, 64'h2_0000, '0, '0, 3'd3, 1'b0));
        drive_item(make_item(OP_RESERVED, {$urandom, $urandom}, {$urandom, $urandom},
                             13'h1FFF, 3'd4, 1'b1));
        repeat (5) drive_item(make_item(OP_NEXT_FREE_RUN, '0, '0, '0, PAGE_FREE, 1'b0));
        drive_item(make_item(OP_MARK_RANGE, '0, 64'(4096) << PAGE_SHIFT, '0, PAGE_FREE, 1'b1));
        drive_item(make_item(OP_SET_RANGE, '0, '0, 13'd4096, PAGE_FREE, 1'b0));
        drive_item(make_item(OP_NEXT_FREE_RUN, '0, '0, '0, PAGE_FREE, 1'b0));
        settle(PHASE_PAUSE);

        write_page_count(13'd4096);
        drive_random(10, 4096);
        settle(PHASE_PAUSE);

        // A long receiver stall halfway through makes the block back up its input.
        write_page_count(13'd64);
        drive_random(25, 64);
        hold_off_request = 1'b1;
        drive_random(25, 64);
        settle(PHASE_PAUSE);

        write_page_count(13'd1);
        drive_random(15, 1);
        settle(PHASE_PAUSE);

        write_page_count(13'd200);
        send_steady = 1'b1;
        drive_random(20, 200);
        send_steady = 1'b0;
        drive_random(15, 200);
        settle(PHASE_PAUSE);

        write_page_count(13'd0);
        drive_random(5, 0);
        settle(DRAIN_CYCLES);

        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end
endmodule
